@@ rtl/ccmfr_pkg.sv @@
// ----------------------------------------------------------------------------
// CAN multi-frame reassembler package
// Shared types and constants for the frame control path, the byte lanes and
// the checksum merge stage.
// ----------------------------------------------------------------------------
package ccmfr_pkg;

	localparam int LANES       = 7;
	localparam int FIRST_BYTES = 4;
	localparam int POS_W       = 17;
	localparam int CNT_W       = 3;
	localparam int ID_W        = 29;
	localparam int DATA_W      = 64;
	localparam int BYTES_W     = LANES * 8;
	localparam int SUM_W       = 16;
	localparam int LSUM_W      = 11;

	typedef enum logic [0:0] {
		PH_IDLE = 1'b0,
		PH_RECV = 1'b1
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_RECV = 2'd1,
		ST_DONE = 2'd2
	} status_t;

	typedef struct packed {
		logic       sum_en;
		logic       low_en;
		logic       high_en;
		logic [7:0] data;
	} lane_res_t;

	typedef struct packed {
		logic               open;
		logic               fin;
		status_t            status;
		logic [POS_W-1:0]   offset;
		logic [CNT_W-1:0]   count;
		logic [POS_W-1:0]   base;
		logic [POS_W-1:0]   total;
		logic [BYTES_W-1:0] data;
	} frame_ctl_t;

	typedef struct packed {
		logic                   open;
		logic                   fin;
		status_t                status;
		logic [POS_W-1:0]       offset;
		logic [CNT_W-1:0]       count;
		lane_res_t [LANES-1:0]  lanes;
	} lane_bus_t;

endpackage

@@ rtl/ccmfr_lane.sv @@
// ----------------------------------------------------------------------------
// Byte lane
// Classifies one stored byte by its stream position: payload byte, low
// checksum byte or high checksum byte.
// ----------------------------------------------------------------------------
module ccmfr_lane
	import ccmfr_pkg::*;
(
	input  logic             en,
	input  logic [POS_W-1:0] pos,
	input  logic [POS_W-1:0] total,
	input  logic [7:0]       data,
	output lane_res_t        res
);

	logic [POS_W-1:0] chk_pos;

	assign chk_pos = total - POS_W'(2);

	always_comb begin
		res.sum_en  = en && (pos < chk_pos);
		res.low_en  = en && (pos == chk_pos);
		res.high_en = en && (pos == total - POS_W'(1));
		res.data    = en ? data : 8'd0;
	end

endmodule

@@ rtl/ccmfr_ctrl.sv @@
// ----------------------------------------------------------------------------
// Frame control
// Tracks the message identifier, sequence number and byte counts, and sorts
// each frame into open, middle, final or drop.
// ----------------------------------------------------------------------------
module ccmfr_ctrl
	import ccmfr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [ID_W-1:0]   frame_id,
	input  logic [DATA_W-1:0] frame_data,
	output frame_ctl_t        ctl
);

	phase_t           phase_q, phase_d;
	logic [ID_W-1:0]  msg_id_q;
	logic [7:0]       frames_q;
	logic [7:0]       last_seq_q;
	logic [POS_W-1:0] total_q;
	logic [POS_W-1:0] recv_q;

	logic [7:0]       seq;
	logic             restart;
	logic             do_open;
	logic             in_seq;
	logic             do_mid;
	logic             do_fin;
	logic [POS_W-1:0] rem;
	logic [POS_W-1:0] new_total;

	assign seq       = frame_data[7:0];
	assign restart   = (phase_q != PH_RECV) || (frame_id != msg_id_q);
	assign do_open   = restart && (seq == 8'd1);
	assign in_seq    = !restart && ({1'b0, seq} == ({1'b0, last_seq_q} + 9'd1));
	assign do_mid    = in_seq && (seq != frames_q);
	assign rem       = total_q - recv_q;
	assign do_fin    = in_seq && (seq == frames_q) && (total_q > recv_q)
		&& (rem <= POS_W'(LANES));
	assign new_total = {1'b0, frame_data[31:24], frame_data[23:16]} + POS_W'(2);

	always_comb begin
		phase_d = PH_IDLE;
		if (do_open || do_mid) begin
			phase_d = PH_RECV;
		end
	end

	always_comb begin
		ctl.open   = do_open;
		ctl.fin    = do_fin;
		ctl.status = ST_IDLE;
		ctl.offset = '0;
		ctl.count  = '0;
		ctl.base   = recv_q;
		ctl.total  = total_q;
		ctl.data   = frame_data[DATA_W-1:8];
		if (do_open) begin
			ctl.status = ST_RECV;
			ctl.count  = CNT_W'(FIRST_BYTES);
			ctl.base   = '0;
			ctl.total  = new_total;
			ctl.data   = {24'd0, frame_data[DATA_W-1:32]};
		end else if (do_mid) begin
			ctl.status = ST_RECV;
			ctl.offset = recv_q;
			ctl.count  = CNT_W'(LANES);
		end else if (do_fin) begin
			ctl.offset = recv_q;
			ctl.count  = rem[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			msg_id_q   <= '0;
			frames_q   <= '0;
			last_seq_q <= '0;
			total_q    <= '0;
			recv_q     <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			if (do_open) begin
				msg_id_q   <= frame_id;
				frames_q   <= frame_data[15:8];
				last_seq_q <= 8'd1;
				total_q    <= new_total;
				recv_q     <= POS_W'(FIRST_BYTES);
			end else if (do_mid) begin
				last_seq_q <= seq;
				recv_q     <= recv_q + POS_W'(LANES);
			end
		end
	end

endmodule

@@ rtl/ccmfr_merge.sv @@
// ----------------------------------------------------------------------------
// Checksum merge and result register
// Folds the lane bytes into the running sum, captures the checksum bytes and
// holds the result until the transfer completes.
// ----------------------------------------------------------------------------
module ccmfr_merge
	import ccmfr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  lane_bus_t           lane_bus,
	output logic                take,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [1:0]          status,
	output logic [POS_W-1:0]    write_offset,
	output logic [CNT_W-1:0]    byte_count,
	output logic [BYTES_W-1:0]  stored_bytes
);

	logic [SUM_W-1:0]   sum_q;
	logic [7:0]         low_q;
	logic [7:0]         high_q;
	logic [LSUM_W-1:0]  lane_sum;
	logic [SUM_W-1:0]   sum_d;
	logic [7:0]         low_d;
	logic [7:0]         high_d;
	logic [BYTES_W-1:0] bytes_d;
	status_t            status_d;

	assign take = in_valid && (!m_tvalid || m_tready);

	always_comb begin
		lane_sum = '0;
		low_d    = lane_bus.open ? 8'd0 : low_q;
		high_d   = lane_bus.open ? 8'd0 : high_q;
		for (int i = 0; i < LANES; i++) begin
			if (lane_bus.lanes[i].sum_en) begin
				lane_sum = lane_sum + LSUM_W'(lane_bus.lanes[i].data);
			end
			if (lane_bus.lanes[i].low_en) begin
				low_d = lane_bus.lanes[i].data;
			end
			if (lane_bus.lanes[i].high_en) begin
				high_d = lane_bus.lanes[i].data;
			end
			bytes_d[i*8 +: 8] = lane_bus.lanes[i].data;
		end
		sum_d = (lane_bus.open ? SUM_W'(0) : sum_q) + SUM_W'(lane_sum);
	end

	always_comb begin
		status_d = lane_bus.status;
		if (lane_bus.fin) begin
			status_d = (sum_d == {high_d, low_d}) ? ST_DONE : ST_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			sum_q    <= '0;
			low_q    <= '0;
			high_q   <= '0;
		end else if (take) begin
			m_tvalid <= 1'b1;
			sum_q    <= sum_d;
			low_q    <= low_d;
			high_q   <= high_d;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status       <= status_d;
			write_offset <= lane_bus.offset;
			byte_count   <= lane_bus.count;
			stored_bytes <= bytes_d;
		end
	end

endmodule

@@ rtl/can_multi_frame_reassembler.sv @@
// ----------------------------------------------------------------------------
// CAN multi-frame reassembler
// Rebuilds a multi-frame message from received frames, reporting the bytes
// to store and the checksum status for every frame.
//
//   channel  dir  width  contents
//   s_*      in   96     frame_id, frame_data
//   m_*      out  80     status, write_offset, byte_count, stored_bytes
//
// One frame per cycle sustained while the output is not stalled; each result
// is registered in the lane stage on its transfer, then in the checksum merge.
// The seven byte lanes and the running sum are fixed width, so no frame
// takes longer. Reset clears the tracker and both stage valids at once.
// A stalled output holds the result; the lane stage keeps taking frames
// until it is full.
// ----------------------------------------------------------------------------
module can_multi_frame_reassembler
	import ccmfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // frame_id[28:0], frame_data[92:29], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata   // status[1:0], write_offset[18:2],
	                              // byte_count[21:19], stored_bytes[77:22], zero pad
);

	logic                  accept;
	logic                  take;
	logic                  valid_s1;
	lane_bus_t             bus_s1;
	lane_bus_t             bus_d;
	frame_ctl_t            ctl;
	lane_res_t [LANES-1:0] lane_res;
	logic [1:0]            status;
	logic [POS_W-1:0]      write_offset;
	logic [CNT_W-1:0]      byte_count;
	logic [BYTES_W-1:0]    stored_bytes;

	assign s_tready = !valid_s1 || take;
	assign accept   = s_tvalid && s_tready;

	ccmfr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.frame_id   (s_tdata[ID_W-1:0]),
		.frame_data (s_tdata[ID_W+DATA_W-1:ID_W]),
		.ctl        (ctl)
	);

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		ccmfr_lane u_lane (
			.en    (CNT_W'(i) < ctl.count),
			.pos   (ctl.base + POS_W'(i)),
			.total (ctl.total),
			.data  (ctl.data[i*8 +: 8]),
			.res   (lane_res[i])
		);
	end

	always_comb begin
		bus_d.open   = ctl.open;
		bus_d.fin    = ctl.fin;
		bus_d.status = ctl.status;
		bus_d.offset = ctl.offset;
		bus_d.count  = ctl.count;
		bus_d.lanes  = lane_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bus_s1 <= bus_d;
		end
	end

	ccmfr_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (valid_s1),
		.lane_bus     (bus_s1),
		.take         (take),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.status       (status),
		.write_offset (write_offset),
		.byte_count   (byte_count),
		.stored_bytes (stored_bytes)
	);

	assign m_tdata = {2'b00, stored_bytes, byte_count, write_offset, status};

endmodule
